@@ src/hfn_pkg.sv @@
// hfn_pkg: shared constants and types of the heightfield normal generator
`timescale 1ns / 1ps
package hfn_pkg;

	localparam int MAX_GRID_WIDTH  = 1024;
	localparam int COL_W           = $clog2(MAX_GRID_WIDTH);
	localparam int ROW_W           = 12;
	localparam int MAX_GRID_HEIGHT = 4095;
	localparam int H_W             = 16;
	localparam int GW_W            = 11;
	localparam int GAIN_W          = 16;
	localparam int SLOPE_W         = 31;
	localparam int LEN_W           = 32;
	localparam int QUO_W           = 15;

	localparam logic [SLOPE_W-1:0] SLOPE_MAX = {SLOPE_W{1'b1}};
	localparam logic [31:0]        ONE_Q16   = 32'd65536;
	localparam logic [QUO_W-1:0]   UNIT_Q14  = 15'd16384;

	// register indexes on the configuration port
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_V_GAIN      = 2'd2;
	localparam logic [1:0] REG_INV_CELL    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_PICK,
		ST_MUL1, ST_MUL2, ST_SAT, ST_SQ, ST_SUM, ST_SQRT, ST_DINIT, ST_DIV, ST_EMIT
	} state_t;

	// one normal to be computed
	typedef struct packed {
		logic              neg_x;
		logic [H_W-1:0]    mag_x;
		logic              step2_x;
		logic              neg_z;
		logic [H_W-1:0]    mag_z;
		logic              step2_z;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              last;
	} job_t;

endpackage

@@ src/heightfield_normal_generator_core.sv @@
// heightfield_normal_generator_core: line stores and iterative normal unit
`timescale 1ns / 1ps
// Each item first passes the line store access states (RD0 to RD4), then each of its normals goes
// through multiply, saturate, square, a bit-serial square root and three parallel bit-serial dividers.
// A new item is accepted only in the idle state, once all normals of the previous item are done.
// A finished normal waits in the output register while the next item is accepted.
// Reset clears counters, control and configuration (256, 256, 256, 256); line stores are not
// cleared and hold undefined data until written.
module heightfield_normal_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // height_sample
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // out_column, out_row, normal_x, normal_y, normal_z, zeros
	output logic        m_axis_tlast    // last_of_run
);

	localparam int CW = hfn_pkg::COL_W;
	localparam int RW = hfn_pkg::ROW_W;
	localparam int HW = hfn_pkg::H_W;

	hfn_pkg::state_t state_q, state_d;

	// configuration
	logic [hfn_pkg::GW_W-1:0]   cfg_width_q;
	logic [RW-1:0]              cfg_height_q;
	logic [hfn_pkg::GAIN_W-1:0] cfg_gain_q, cfg_ics_q;

	// counters and item registers
	logic [CW-1:0] col_q, x_q;
	logic [RW-1:0] row_q, y_q;
	logic [HW-1:0] h_q;
	logic          at_left_q, at_right_q, y_one_q, last_row_q, x_one_q;

	// line stores
	logic [HW-1:0] prev_mem  [hfn_pkg::MAX_GRID_WIDTH];
	logic [HW-1:0] older_mem [hfn_pkg::MAX_GRID_WIDTH];
	logic [HW-1:0] prev_rd_q, older_rd_q;
	logic [CW-1:0] prev_raddr, older_raddr;
	logic          prev_re, older_re, mem_we;
	logic [HW-1:0] px_q, ox_q, px1_q, om1_q, pm1_q, pm2_q;

	// jobs and arithmetic
	logic [2:0]                  job_q;
	hfn_pkg::job_t               cur_q, pick;
	logic [1:0]                  pick_idx;
	logic [31:0]                 px_prod_q, pz_prod_q;
	logic [47:0]                 qx_prod_q, qz_prod_q;
	logic [hfn_pkg::SLOPE_W-1:0] sx_q, sz_q;
	logic [61:0]                 sxx_q, szz_q;
	logic [63:0]                 sq_s_q;
	logic [hfn_pkg::LEN_W-1:0]   root_q;
	logic [34:0]                 rem_q;
	logic [4:0]                  cnt_q;
	logic [31:0]                 drem_q [3];
	logic [14:0]                 dlo_q  [3];
	logic [hfn_pkg::QUO_W-1:0]   quo_q  [3];

	// output register
	logic        out_valid_q, out_last_q;
	logic [71:0] out_data_q;
	logic        out_free;

	// geometry of the current configuration
	logic [hfn_pkg::GW_W-1:0] w_cl;
	logic [CW-1:0]            w_m1, x_now;
	logic [RW-1:0]            ht_m1, y_now;
	logic                     accept;

	always_comb begin
		if (cfg_width_q < 11'd2)
			w_cl = 11'd2;
		else if (cfg_width_q > 11'(hfn_pkg::MAX_GRID_WIDTH))
			w_cl = 11'(hfn_pkg::MAX_GRID_WIDTH);
		else
			w_cl = cfg_width_q;
		w_m1  = CW'(w_cl - 11'd1);
		ht_m1 = (cfg_height_q < 12'd2) ? 12'd1 : cfg_height_q - 12'd1;
		x_now = (col_q > w_m1) ? w_m1 : col_q;
		y_now = (row_q > ht_m1) ? ht_m1 : row_q;
	end

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == hfn_pkg::ST_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;

	// configuration port
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[3:2])
			hfn_pkg::REG_GRID_WIDTH:  prdata = {21'd0, cfg_width_q};
			hfn_pkg::REG_GRID_HEIGHT: prdata = {20'd0, cfg_height_q};
			hfn_pkg::REG_V_GAIN:      prdata = {16'd0, cfg_gain_q};
			hfn_pkg::REG_INV_CELL:    prdata = {16'd0, cfg_ics_q};
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= 11'd256;
			cfg_height_q <= 12'd256;
			cfg_gain_q   <= 16'd256;
			cfg_ics_q    <= 16'd256;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				hfn_pkg::REG_GRID_WIDTH:  cfg_width_q  <= pwdata[10:0];
				hfn_pkg::REG_GRID_HEIGHT: cfg_height_q <= pwdata[11:0];
				hfn_pkg::REG_V_GAIN:      cfg_gain_q   <= pwdata[15:0];
				hfn_pkg::REG_INV_CELL:    cfg_ics_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// line stores, one read and one write port each
	always_ff @(posedge clk) begin
		if (mem_we) begin
			prev_mem[x_q]  <= h_q;
			older_mem[x_q] <= px_q;
		end
		if (prev_re)
			prev_rd_q <= prev_mem[prev_raddr];
		if (older_re)
			older_rd_q <= older_mem[older_raddr];
	end

	// job selection: normal of the row above, then last-row normals
	function automatic hfn_pkg::job_t make_job(input logic [HW-1:0] left, input logic [HW-1:0] right,
		input logic sx2, input logic [HW-1:0] down, input logic [HW-1:0] up, input logic sz2,
		input logic [CW-1:0] col, input logic [RW-1:0] row, input logic last);
		hfn_pkg::job_t j;
		logic [HW:0] dx, dz;
		dx = {right[HW-1], right} - {left[HW-1], left};
		dz = {up[HW-1], up} - {down[HW-1], down};
		j.neg_x   = !dx[HW] && (dx != '0);
		j.mag_x   = dx[HW] ? HW'(-dx) : dx[HW-1:0];
		j.step2_x = sx2;
		j.neg_z   = !dz[HW] && (dz != '0);
		j.mag_z   = dz[HW] ? HW'(-dz) : dz[HW-1:0];
		j.step2_z = sz2;
		j.col     = col;
		j.row     = row;
		j.last    = last;
		return j;
	endfunction

	always_comb begin
		pick_idx = 2'd0;
		if (job_q[0]) begin
			pick_idx = 2'd0;
			pick = make_job(at_left_q ? px_q : om1_q, at_right_q ? px_q : px1_q,
				!(at_left_q || at_right_q), y_one_q ? px_q : ox_q, h_q, !y_one_q,
				x_q, y_q - 12'd1, !job_q[1] && !job_q[2]);
		end else if (job_q[1]) begin
			pick_idx = 2'd1;
			pick = make_job(x_one_q ? pm1_q : pm2_q, h_q, !x_one_q, om1_q, pm1_q, 1'b0,
				x_q - CW'(1), y_q, !job_q[2]);
		end else begin
			pick_idx = 2'd2;
			pick = make_job(pm1_q, h_q, 1'b0, px_q, h_q, 1'b0, x_q, y_q, 1'b1);
		end
	end

	// next state and memory control
	always_comb begin
		state_d     = state_q;
		prev_re     = 1'b0;
		older_re    = 1'b0;
		mem_we      = 1'b0;
		prev_raddr  = x_q;
		older_raddr = x_q;
		unique case (state_q)
			hfn_pkg::ST_IDLE: if (accept) state_d = hfn_pkg::ST_RD0;
			hfn_pkg::ST_RD0: begin
				prev_re  = 1'b1;
				older_re = 1'b1;
				state_d  = hfn_pkg::ST_RD1;
			end
			hfn_pkg::ST_RD1: begin
				prev_re     = 1'b1;
				older_re    = 1'b1;
				prev_raddr  = x_q + CW'(1);
				older_raddr = x_q - CW'(1);
				state_d     = hfn_pkg::ST_RD2;
			end
			hfn_pkg::ST_RD2: begin
				prev_re    = 1'b1;
				prev_raddr = x_q - CW'(1);
				state_d    = hfn_pkg::ST_RD3;
			end
			hfn_pkg::ST_RD3: begin
				prev_re    = 1'b1;
				prev_raddr = x_q - CW'(2);
				state_d    = hfn_pkg::ST_RD4;
			end
			hfn_pkg::ST_RD4: begin
				mem_we  = 1'b1;
				state_d = hfn_pkg::ST_PICK;
			end
			hfn_pkg::ST_PICK:  state_d = (job_q != '0) ? hfn_pkg::ST_MUL1 : hfn_pkg::ST_IDLE;
			hfn_pkg::ST_MUL1:  state_d = hfn_pkg::ST_MUL2;
			hfn_pkg::ST_MUL2:  state_d = hfn_pkg::ST_SAT;
			hfn_pkg::ST_SAT:   state_d = hfn_pkg::ST_SQ;
			hfn_pkg::ST_SQ:    state_d = hfn_pkg::ST_SUM;
			hfn_pkg::ST_SUM:   state_d = hfn_pkg::ST_SQRT;
			hfn_pkg::ST_SQRT:  if (cnt_q == 5'd31) state_d = hfn_pkg::ST_DINIT;
			hfn_pkg::ST_DINIT: state_d = hfn_pkg::ST_DIV;
			hfn_pkg::ST_DIV:   if (cnt_q == 5'd14) state_d = hfn_pkg::ST_EMIT;
			hfn_pkg::ST_EMIT:  if (out_free) state_d = hfn_pkg::ST_PICK;
			default:           state_d = hfn_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hfn_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// counters, item capture and job flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			job_q <= '0;
		end else begin
			if (accept) begin
				if (x_now == w_m1) begin
					col_q <= '0;
					row_q <= (y_now == ht_m1) ? '0 : y_now + 12'd1;
				end else begin
					col_q <= x_now + CW'(1);
					row_q <= y_now;
				end
			end
			if (state_q == hfn_pkg::ST_RD4)
				job_q <= {last_row_q && at_right_q, last_row_q && (x_q != '0), y_q != '0};
			else if (state_q == hfn_pkg::ST_PICK && job_q != '0)
				job_q[pick_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h_q        <= s_axis_tdata;
			x_q        <= x_now;
			y_q        <= y_now;
			at_left_q  <= (x_now == '0);
			at_right_q <= (x_now == w_m1);
			x_one_q    <= (x_now == CW'(1));
			y_one_q    <= (y_now == 12'd1);
			last_row_q <= (y_now == ht_m1);
		end
		unique case (state_q)
			hfn_pkg::ST_RD1: begin
				px_q <= prev_rd_q;
				ox_q <= older_rd_q;
			end
			hfn_pkg::ST_RD2: begin
				px1_q <= prev_rd_q;
				om1_q <= older_rd_q;
			end
			hfn_pkg::ST_RD3: pm1_q <= prev_rd_q;
			hfn_pkg::ST_RD4: pm2_q <= prev_rd_q;
			default: ;
		endcase
	end

	// normal unit: slopes, squared length, square root, three dividers
	logic [34:0] sqrt_rem_n;
	logic [34:0] sqrt_trial;
	logic [45:0] div_num [3];
	logic [32:0] div_t   [3];
	logic [31:0] div_v   [3];

	always_comb begin
		sqrt_rem_n = {rem_q[32:0], sq_s_q[63:62]};
		sqrt_trial = {1'b0, root_q, 2'b01};
		div_v[0] = {1'b0, sx_q};
		div_v[1] = hfn_pkg::ONE_Q16;
		div_v[2] = {1'b0, sz_q};
		for (int i = 0; i < 3; i++) begin
			div_num[i] = {div_v[i], 14'd0} + 46'(root_q[31:1]);
			div_t[i]   = {drem_q[i], dlo_q[i][14]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (state_q == hfn_pkg::ST_SUM || state_q == hfn_pkg::ST_DINIT)
			cnt_q <= '0;
		else if (state_q == hfn_pkg::ST_SQRT || state_q == hfn_pkg::ST_DIV)
			cnt_q <= cnt_q + 5'd1;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			hfn_pkg::ST_PICK: cur_q <= pick;
			hfn_pkg::ST_MUL1: begin
				px_prod_q <= cur_q.mag_x * cfg_gain_q;
				pz_prod_q <= cur_q.mag_z * cfg_gain_q;
			end
			hfn_pkg::ST_MUL2: begin
				qx_prod_q <= px_prod_q * cfg_ics_q;
				qz_prod_q <= pz_prod_q * cfg_ics_q;
			end
			hfn_pkg::ST_SAT: begin
				logic [47:0] tx, tz;
				tx = cur_q.step2_x ? (qx_prod_q >> 1) : qx_prod_q;
				tz = cur_q.step2_z ? (qz_prod_q >> 1) : qz_prod_q;
				sx_q <= (tx > 48'(hfn_pkg::SLOPE_MAX)) ? hfn_pkg::SLOPE_MAX : tx[30:0];
				sz_q <= (tz > 48'(hfn_pkg::SLOPE_MAX)) ? hfn_pkg::SLOPE_MAX : tz[30:0];
			end
			hfn_pkg::ST_SQ: begin
				sxx_q <= sx_q * sx_q;
				szz_q <= sz_q * sz_q;
			end
			hfn_pkg::ST_SUM: begin
				sq_s_q <= 64'(sxx_q) + 64'(szz_q) + 64'h1_0000_0000;
				root_q <= '0;
				rem_q  <= '0;
			end
			hfn_pkg::ST_SQRT: begin
				sq_s_q <= {sq_s_q[61:0], 2'b00};
				if (sqrt_rem_n >= sqrt_trial) begin
					rem_q  <= sqrt_rem_n - sqrt_trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= sqrt_rem_n;
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			hfn_pkg::ST_DINIT: begin
				for (int i = 0; i < 3; i++) begin
					drem_q[i] <= {1'b0, div_num[i][45:15]};
					dlo_q[i]  <= div_num[i][14:0];
					quo_q[i]  <= '0;
				end
			end
			hfn_pkg::ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					dlo_q[i] <= {dlo_q[i][13:0], 1'b0};
					if (div_t[i] >= {1'b0, root_q}) begin
						drem_q[i] <= 32'(div_t[i] - {1'b0, root_q});
						quo_q[i]  <= {quo_q[i][13:0], 1'b1};
					end else begin
						drem_q[i] <= div_t[i][31:0];
						quo_q[i]  <= {quo_q[i][13:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	logic [15:0] nx_out, nz_out;
	always_comb begin
		nx_out = cur_q.neg_x ? 16'(-{1'b0, quo_q[0]}) : {1'b0, quo_q[0]};
		nz_out = cur_q.neg_z ? 16'(-{1'b0, quo_q[2]}) : {1'b0, quo_q[2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == hfn_pkg::ST_EMIT && out_free)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == hfn_pkg::ST_EMIT && out_free) begin
			out_data_q <= {3'd0, nz_out, quo_q[1], nx_out, cur_q.row, cur_q.col};
			out_last_q <= cur_q.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// checks
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == hfn_pkg::ST_RD0) else $error("accepted item did not start reads");
	a_idle_no_jobs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hfn_pkg::ST_IDLE |-> job_q == '0) else $error("jobs left pending in idle");
	a_len_min: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hfn_pkg::ST_DINIT |-> root_q >= hfn_pkg::ONE_Q16) else $error("length below one");
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hfn_pkg::ST_EMIT |-> quo_q[0] <= hfn_pkg::UNIT_Q14 && quo_q[1] <= hfn_pkg::UNIT_Q14
		&& quo_q[2] <= hfn_pkg::UNIT_Q14) else $error("normal component above one");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hfn_pkg::ST_EMIT && !out_free |=> state_q == hfn_pkg::ST_EMIT)
		else $error("result dropped while output busy");

endmodule
